FILE: rtl/core/xrr_pkg.sv
// shared constants and widths for the xorshift range generator
package xrr_pkg;

    // field and datapath widths
    localparam int VAL_W   = 32;
    localparam int SPAN_W  = VAL_W + 1;
    localparam int DRAW_W  = 64;
    localparam int DIGIT_W = 2;
    localparam int STEPS   = DRAW_W / DIGIT_W;
    localparam int CNT_W   = $clog2(STEPS);

    // generator constants
    localparam logic [DRAW_W-1:0] GOLDEN_SEED  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [DRAW_W-1:0] STAR_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam logic [DRAW_W-1:0] STAR_MULT_X2 = STAR_MULT << 1;
    localparam logic [DRAW_W-1:0] STAR_MULT_X3 = STAR_MULT + STAR_MULT_X2;

    // xorshift amounts
    localparam int XS_A = 12;
    localparam int XS_B = 25;
    localparam int XS_C = 27;

    // apb address width and register decode
    localparam int ADDR_W = 4;
    localparam logic REG_SEED = 1'b0;

endpackage

FILE: rtl/core/xrr_req_if.sv
// request channel: inclusive range bounds
interface xrr_req_if import xrr_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] range_low;
    logic [VAL_W-1:0] range_high;

    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);

endinterface

FILE: rtl/core/xrr_rsp_if.sv
// result channel: drawn value and range error flag
interface xrr_rsp_if import xrr_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] drawn_value;
    logic             range_error;

    modport source (output valid, drawn_value, range_error, input ready);
    modport sink   (input valid, drawn_value, range_error, output ready);

endinterface

FILE: rtl/core/xrr_mul.sv
// digit-serial multiply of the generator state by the fixed odd constant, modulo 2^64
module xrr_mul import xrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DRAW_W-1:0] i_mplier,
    output logic              o_done,
    output logic [DRAW_W-1:0] o_product
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DRAW_W-1:0] r_mplier;
    logic [DRAW_W-1:0] r_acc;
    logic [DRAW_W-1:0] w_part;

    // constant multiple picked by the top digit
    always_comb begin
        unique case (r_mplier[DRAW_W-1 -: DIGIT_W])
            2'd0:    w_part = '0;
            2'd1:    w_part = STAR_MULT;
            2'd2:    w_part = STAR_MULT_X2;
            default: w_part = STAR_MULT_X3;
        endcase
    end

    // horner accumulation, most significant digit first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mplier <= i_mplier;
            end else if (r_busy) begin
                r_acc    <= (r_acc << DIGIT_W) + w_part;
                r_mplier <= r_mplier << DIGIT_W;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

FILE: rtl/core/xrr_div.sv
// digit-serial remainder of a 64-bit draw by a span of up to 2^32
module xrr_div import xrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DRAW_W-1:0] i_dividend,
    input  logic [SPAN_W-1:0] i_divisor,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DRAW_W-1:0] r_dvd;
    logic [SPAN_W-1:0] r_dsr;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  w_rem_mid;
    logic [VAL_W-1:0]  w_rem_nxt;

    // one restoring step: shift in a bit, subtract the span when it fits
    function automatic logic [VAL_W-1:0] f_step(
        input logic [VAL_W-1:0]  rem_in,
        input logic              bit_in,
        input logic [SPAN_W-1:0] dsr
    );
        logic [SPAN_W-1:0] t;
        t = {rem_in, bit_in};
        if (t >= dsr) begin
            f_step = VAL_W'(t - dsr);
        end else begin
            f_step = VAL_W'(t);
        end
    endfunction

    // two dividend bits per cycle
    assign w_rem_mid = f_step(r_rem, r_dvd[DRAW_W-1], r_dsr);
    assign w_rem_nxt = f_step(w_rem_mid, r_dvd[DRAW_W-2], r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_rem_nxt;
                r_dvd <= r_dvd << DIGIT_W;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/xorshift_range_random_top.sv
// top level: request handling, generator state, rejection check and apb seed register
//
// usage
//   i_req carries an inclusive range (range_low, range_high); o_rsp returns one
//   transaction per request with drawn_value and range_error. The seed register
//   sits at apb byte address 0 (64-bit data); writing it reloads the generator
//   state with the seed, or the golden constant for a zero seed, ORed with one.
//   Write the seed only while no request is in flight.
// sequence
//   one request at a time. A draw takes one xorshift step, a multiply and a
//   remainder unit (two bits a cycle), a subtract and the rejection check; a
//   rejected draw repeats it. The result enters the output register and the
//   next request can be taken in the cycle after. An inverted range goes
//   straight to the output stage, with range_error set and the state left as
//   it was.
// reset and stalls
//   reset loads the state and seed with the golden constant and empties the
//   output register. A finished result waits in the output register; the next
//   request is taken meanwhile, and its result is held until the register frees.
module xorshift_range_random_top import xrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    xrr_req_if.sink           i_req,
    xrr_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DRAW_W-1:0] pwdata,
    output logic [DRAW_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_MUL,
        S_DIV,
        S_SUB,
        S_CHK,
        S_PUT
    } t_fsm;

    t_fsm              r_fsm;
    logic [DRAW_W-1:0] r_state;
    logic [DRAW_W-1:0] r_seed;
    logic [VAL_W-1:0]  r_lo;
    logic [SPAN_W-1:0] r_span;
    logic              r_err;
    logic [DRAW_W-1:0] r_diff;
    logic [VAL_W-1:0]  r_res;
    logic              r_mul_start;
    logic              r_div_start;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_error;

    logic              w_cfg_wr;
    logic              w_inverted;
    logic [DRAW_W-1:0] w_xs;
    logic              w_mul_done;
    logic [DRAW_W-1:0] w_product;
    logic              w_div_done;
    logic [VAL_W-1:0]  w_rem;
    logic [DRAW_W:0]   w_sum;

    // xorshift step of the generator
    function automatic logic [DRAW_W-1:0] f_xorshift(input logic [DRAW_W-1:0] s_in);
        logic [DRAW_W-1:0] s;
        s = s_in;
        s = s ^ (s >> XS_A);
        s = s ^ (s << XS_B);
        s = s ^ (s >> XS_C);
        f_xorshift = s;
    endfunction

    assign w_xs       = f_xorshift(r_state);
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_SEED);
    assign w_inverted = i_req.range_high < i_req.range_low;

    // next multiple of the span past the draw's own overflows when the draw is rejected
    assign w_sum = {1'b0, r_diff} + (DRAW_W + 1)'(r_span);

    // serial multiplier
    xrr_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_mplier  (r_state),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // serial remainder unit
    xrr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_product),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // sequencer, generator state, seed register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= GOLDEN_SEED;
            r_seed      <= GOLDEN_SEED;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            // output empties once taken, unless a new result replaces it
            if (o_rsp.valid && o_rsp.ready && (r_fsm != S_PUT)) begin
                r_out_valid <= 1'b0;
            end
            // generator state: advance on a draw, reload on a seed write
            if (r_fsm == S_ADV) begin
                r_state <= w_xs;
            end else if (w_cfg_wr) begin
                r_state <= ((pwdata != '0) ? pwdata : GOLDEN_SEED) | DRAW_W'(1);
            end
            if (w_cfg_wr) begin
                r_seed <= pwdata;
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_lo   <= i_req.range_low;
                        r_span <= {1'b0, i_req.range_high} - {1'b0, i_req.range_low}
                                  + SPAN_W'(1);
                        r_err  <= w_inverted;
                        r_res  <= '0;
                        r_fsm  <= w_inverted ? S_PUT : S_ADV;
                    end
                end
                S_ADV: begin
                    r_mul_start <= 1'b1;
                    r_fsm       <= S_MUL;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_div_start <= 1'b1;
                        r_fsm       <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_fsm <= S_SUB;
                    end
                end
                S_SUB: begin
                    r_diff <= w_product - DRAW_W'(w_rem);
                    r_fsm  <= S_CHK;
                end
                S_CHK: begin
                    if (w_sum[DRAW_W]) begin
                        r_fsm <= S_ADV;
                    end else begin
                        r_res <= r_lo + w_rem;
                        r_fsm <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res;
                        r_out_error <= r_err;
                        r_fsm       <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign i_req.ready       = (r_fsm == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.drawn_value = r_out_value;
    assign o_rsp.range_error = r_out_error;
    assign prdata            = r_seed;
    assign pready            = 1'b1;

    // generator state never reaches zero
    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != '0)
        else $error("generator state is zero");

    // flagged results carry a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.range_error) |-> (o_rsp.drawn_value == '0))
        else $error("flagged result with non-zero value");

    // remainder is below the span when the unit finishes
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ({1'b0, w_rem} < r_span))
        else $error("remainder not below span");

    // rejection check always follows the subtract
    a_chk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_CHK) |-> ($past(r_fsm) == S_SUB))
        else $error("rejection check entered out of order");

endmodule
